[src/srpm_pkg.sv]
// ----------------------------------------------------------------------------
// srpm_pkg
// Shared types and constants for the serial response pattern matcher.
// ----------------------------------------------------------------------------
package srpm_pkg;

  localparam int NUM_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 8;
  localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;
  localparam int FILL_W          = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W           = 4;
  localparam int CODE_W          = 8;
  localparam int COUNT_W         = 3;
  localparam int IDX_W           = 2;
  localparam int SEEN_W          = 15;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_A   = 3'd0,
    CFG_PATTERN_B   = 3'd1,
    CFG_PATTERN_C   = 3'd2,
    CFG_PATTERN_D   = 3'd3,
    CFG_LENGTHS     = 3'd4,
    CFG_CODES       = 3'd5,
    CFG_COUNT       = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_BYTE    = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              done_res;
    logic [CODE_W-1:0] match_code;
    logic [SEEN_W-1:0] byte_count;
  } out_item_t;

endpackage

[src/serial_response_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// serial_response_pattern_matcher
// Matches a received byte stream against up to four configured strings.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in_      | input     | in_valid / in_stall | req_type, rx_byte
//  out_     | output    | out_valid/out_stall | done_res, match_code, byte_count
//  cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; an accepted item's result is
//  registered in the output register, or in the skid if that is stalled. All
//  compares are made on the new byte in the accept cycle. A two-entry output
//  buffer (output register plus skid) lets an item in while the previous
//  result is stalled; in_stall rises only when both are full. Synchronous
//  reset clears state and configuration. cfg_ready is always high.
//
module serial_response_pattern_matcher (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  srpm_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output srpm_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [srpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srpm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration
  logic [63:0]                         pat_r [4];
  logic [4*srpm_pkg::LEN_W-1:0]        lengths_r;
  logic [4*srpm_pkg::CODE_W-1:0]       codes_r;
  logic [srpm_pkg::COUNT_W-1:0]        count_r;

  // watch state
  logic [7:0]                          hist_r [srpm_pkg::HIST_DEPTH];
  logic [srpm_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic                                latched_r, latched_nxt;
  logic [srpm_pkg::IDX_W-1:0]          lidx_r, lidx_nxt;
  logic [srpm_pkg::SEEN_W-1:0]         seen_r, seen_nxt;

  // output buffer
  logic                                out_valid_r, out_valid_nxt;
  logic                                skid_valid_r, skid_valid_nxt;
  srpm_pkg::out_item_t                 out_data_r, out_data_nxt;
  srpm_pkg::out_item_t                 skid_data_r, skid_data_nxt;

  logic                                in_acc, out_take, cfg_we;
  logic [srpm_pkg::COUNT_W-1:0]        n_act;
  logic [srpm_pkg::NUM_PATTERNS-1:0]   hit;
  srpm_pkg::out_item_t                 res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_take  = out_valid_r && !out_stall;

  assign n_act = (count_r > srpm_pkg::COUNT_W'(srpm_pkg::NUM_PATTERNS)) ?
                 srpm_pkg::COUNT_W'(srpm_pkg::NUM_PATTERNS) : count_r;

  // per-pattern compare against the window ending on the new byte
  always_comb begin
    logic [srpm_pkg::LEN_W-1:0] len;
    logic [7:0]                 have;
    logic                       ok;
    for (int i = 0; i < srpm_pkg::NUM_PATTERNS; i++) begin
      len = lengths_r[srpm_pkg::LEN_W*i +: srpm_pkg::LEN_W];
      if (len > srpm_pkg::LEN_W'(srpm_pkg::MAX_PATTERN_LEN)) begin
        len = srpm_pkg::LEN_W'(srpm_pkg::MAX_PATTERN_LEN);
      end
      ok = 1'b1;
      if (len != '0 && (len - 1'b1) > srpm_pkg::LEN_W'(fill_r)) begin
        ok = 1'b0;
      end
      for (int k = 0; k < srpm_pkg::MAX_PATTERN_LEN; k++) begin
        have = (k == 0) ? in_data.rx_byte : hist_r[(k == 0) ? 0 : k - 1];
        if (srpm_pkg::LEN_W'(k) < len && pat_r[i][8*k +: 8] != have) begin
          ok = 1'b0;
        end
      end
      hit[i] = ok && (srpm_pkg::COUNT_W'(i) < n_act);
    end
  end

  // next watch state and result
  always_comb begin
    fill_nxt    = fill_r;
    latched_nxt = latched_r;
    lidx_nxt    = lidx_r;
    seen_nxt    = seen_r;
    if (in_data.req_type == srpm_pkg::REQ_RESTART) begin
      fill_nxt    = '0;
      latched_nxt = 1'b0;
      lidx_nxt    = '0;
      seen_nxt    = '0;
    end else begin
      seen_nxt = seen_r + 1'b1;
      for (int i = srpm_pkg::NUM_PATTERNS - 1; i >= 0; i--) begin
        if (hit[i]) begin
          latched_nxt = 1'b1;
          lidx_nxt    = srpm_pkg::IDX_W'(i);
        end
      end
      if (fill_r < srpm_pkg::FILL_W'(srpm_pkg::HIST_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end

    res.byte_count = seen_nxt;
    res.done_res   = 1'b0;
    res.match_code = '0;
    if (n_act == '0) begin
      res.done_res = 1'b1;
    end else if (latched_nxt && {1'b0, lidx_nxt} < n_act) begin
      res.done_res   = 1'b1;
      res.match_code = codes_r[srpm_pkg::CODE_W*lidx_nxt +: srpm_pkg::CODE_W];
    end
  end

  // output register and skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      fill_r       <= '0;
      latched_r    <= 1'b0;
      lidx_r       <= '0;
      seen_r       <= '0;
      for (int j = 0; j < srpm_pkg::HIST_DEPTH; j++) begin
        hist_r[j] <= '0;
      end
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_acc) begin
        fill_r    <= fill_nxt;
        latched_r <= latched_nxt;
        lidx_r    <= lidx_nxt;
        seen_r    <= seen_nxt;
        if (in_data.req_type == srpm_pkg::REQ_RESTART) begin
          for (int j = 0; j < srpm_pkg::HIST_DEPTH; j++) begin
            hist_r[j] <= '0;
          end
        end else begin
          hist_r[0] <= in_data.rx_byte;
          for (int j = 1; j < srpm_pkg::HIST_DEPTH; j++) begin
            hist_r[j] <= hist_r[j-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) begin
        pat_r[j] <= '0;
      end
      lengths_r <= '0;
      codes_r   <= '0;
      count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srpm_pkg::CFG_PATTERN_A: pat_r[0]  <= cfg_data;
        srpm_pkg::CFG_PATTERN_B: pat_r[1]  <= cfg_data;
        srpm_pkg::CFG_PATTERN_C: pat_r[2]  <= cfg_data;
        srpm_pkg::CFG_PATTERN_D: pat_r[3]  <= cfg_data;
        srpm_pkg::CFG_LENGTHS:   lengths_r <= cfg_data[4*srpm_pkg::LEN_W-1:0];
        srpm_pkg::CFG_CODES:     codes_r   <= cfg_data[4*srpm_pkg::CODE_W-1:0];
        srpm_pkg::CFG_COUNT:     count_r   <= cfg_data[srpm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid valid without output valid");

  // restart clears the watch state
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == srpm_pkg::REQ_RESTART) |=>
      (seen_r == '0 && !latched_r && fill_r == '0))
    else $error("restart did not clear watch state");

  // each received byte advances the counter by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == srpm_pkg::REQ_BYTE) |=>
      (seen_r == $past(seen_r) + 1'b1))
    else $error("byte counter did not advance");

endmodule
